@@ hdl/lph_pkg.sv @@
package lph_pkg;

	// Number of slots built into the table memory.
	localparam int CAPACITY = 1024;

	// Field widths fixed by the interface.
	localparam int CMD_W      = 2;
	localparam int KEY_W      = 31;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 10;
	localparam int CFG_W      = 11;

	// Internal widths that follow the table capacity and the key width.
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int SIZE_W = $clog2(CAPACITY + 1);
	localparam int BIT_CNT_W = $clog2(KEY_W);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// One word of the table memory.
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} entry_t;

endpackage

@@ hdl/linear_probe_hash_table.sv @@
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    command, key
// out      output     out_valid / out_ready  status, slot
// cfg      input      cfg_valid / cfg_ready  cfg_data (table_size)
//
// An accepted item goes through the bit-serial key mod table_size unit and then P
// probes before its result is loaded, where P is 1 up to table_size for insert;
// remove and search stop at a match and take all table_size probes when the key is
// absent. The unused command skips the modulo unit and the probes. The probe loop
// issues one table memory read per cycle, one probe per read of the single read port.
// After reset a clearing pass writes every one of the 1024 slots empty, one per
// cycle, and in_ready stays low during the pass; configuration beats are taken.
// A finished result waits in the output register; a new item is accepted meanwhile,
// and the block only stalls if another result is ready before the first is taken.
module linear_probe_hash_table
	import lph_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      command,
	input  logic [KEY_W-1:0]      key,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_OUT_W-1:0] slot,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data
);

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_DIV    = 5'b00100,
		S_PROBE  = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  table_size_q;
	logic [SIZE_W-1:0] size_in_use;
	logic [31:0]       size_wide;

	// Item being worked on.
	cmd_t              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] m_q;

	// Probe pipeline: next_pos_q is the address read this cycle; cmp_pos_q is the
	// slot whose word arrives from the memory this cycle when cmp_vld_q is set.
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] next_pos_q;
	logic [SLOT_W-1:0] cmp_pos_q;
	logic              cmp_vld_q;
	logic [SIZE_W-1:0] left_q;
	logic [SIZE_W-1:0] pos_inc;
	logic [SLOT_W-1:0] pos_wrap;

	// Result waiting for the output register, and the output register itself.
	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [SLOT_W-1:0] out_slot_q;

	// Modulo unit and memory connections.
	logic              accept;
	logic              mod_done;
	logic [SLOT_W-1:0] mod_rem;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	entry_t            ram_rdata;

	// Probe decisions for the word now at the memory output.
	logic              hit;
	logic              last_probe;
	logic              probe_stop;
	status_t           probe_status;
	logic              probe_write;
	entry_t            probe_wdata;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// A size of zero is treated as one slot and anything above the capacity as the
	// full capacity.
	assign size_wide = 32'(table_size_q);
	always_comb begin
		if (size_wide == 32'd0) begin
			size_in_use = SIZE_W'(1);
		end else if (size_wide > 32'(CAPACITY)) begin
			size_in_use = SIZE_W'(CAPACITY);
		end else begin
			size_in_use = SIZE_W'(table_size_q);
		end
	end

	lph_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && (command <= CMD_SEARCH)),
		.dividend  (key),
		.divisor   (size_in_use),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// Step to the next slot, wrapping at the size in use.
	assign pos_inc  = SIZE_W'(next_pos_q) + 1'b1;
	assign pos_wrap = (pos_inc >= m_q) ? '0 : SLOT_W'(pos_inc);

	assign hit        = ram_rdata.valid && (ram_rdata.key == key_q);
	assign last_probe = (left_q == SIZE_W'(1));

	// An insert ends at the first empty slot, at a copy of its key, or as full after
	// all slots. Remove and search skip empty slots and end only at a match or after all.
	always_comb begin
		probe_stop   = 1'b0;
		probe_status = ST_NOT_FOUND;
		probe_write  = 1'b0;
		probe_wdata  = '{valid: 1'b0, key: key_q};
		unique case (cmd_q)
			CMD_INSERT: begin
				if (!ram_rdata.valid) begin
					probe_stop   = 1'b1;
					probe_status = ST_OK;
					probe_write  = 1'b1;
					probe_wdata  = '{valid: 1'b1, key: key_q};
				end else if (hit) begin
					probe_stop   = 1'b1;
					probe_status = ST_DUPLICATE;
				end else if (last_probe) begin
					probe_stop   = 1'b1;
					probe_status = ST_FULL;
				end
			end
			CMD_REMOVE: begin
				if (hit) begin
					probe_stop   = 1'b1;
					probe_status = ST_OK;
					probe_write  = 1'b1;
				end else if (last_probe) begin
					probe_stop = 1'b1;
				end
			end
			CMD_SEARCH: begin
				if (hit) begin
					probe_stop   = 1'b1;
					probe_status = ST_OK;
				end else if (last_probe) begin
					probe_stop = 1'b1;
				end
			end
			default: begin
				probe_stop = 1'b1;
			end
		endcase
	end

	// The clearing pass and the probe loop share the one write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cmp_pos_q;
		ram_wdata = probe_wdata;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_PROBE && cmp_vld_q) begin
			ram_we = probe_write;
		end
	end

	assign ram_re = (state_q == S_PROBE);

	lph_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (next_pos_q),
		.rdata (ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			cmp_vld_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			table_size_q <= CFG_W'(CAPACITY);
		end else begin
			if (cfg_valid && cfg_ready) begin
				table_size_q <= cfg_data;
			end
			// The output register is loaded when it is empty or being drained,
			// and otherwise emptied by a taken beat.
			if (state_q == S_RESULT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (command <= CMD_SEARCH) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_DIV: begin
					cmp_vld_q <= 1'b0;
					if (mod_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					cmp_vld_q <= !(cmp_vld_q && probe_stop);
					if (cmp_vld_q && probe_stop) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= cmd_t'(command);
			key_q        <= key;
			m_q          <= size_in_use;
			res_status_q <= ST_NOT_FOUND;
			res_slot_q   <= '0;
		end
		if (state_q == S_DIV && mod_done) begin
			next_pos_q <= mod_rem;
			left_q     <= m_q;
		end
		if (state_q == S_PROBE) begin
			next_pos_q <= pos_wrap;
			cmp_pos_q  <= next_pos_q;
			if (cmp_vld_q) begin
				left_q <= left_q - 1'b1;
				if (probe_stop) begin
					res_status_q <= probe_status;
					if (probe_status == ST_OK || probe_status == ST_DUPLICATE) begin
						res_slot_q <= cmp_pos_q;
					end else begin
						res_slot_q <= '0;
					end
				end
			end
		end
		if (state_q == S_RESULT && (!out_valid_q || out_ready)) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign slot      = SLOT_OUT_W'(out_slot_q);

endmodule

@@ hdl/lph_ram.sv @@
module lph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/lph_mod.sv @@
module lph_mod
	import lph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [SLOT_W-1:0] remainder
);

	// Restoring remainder: one dividend bit is brought down per cycle.
	logic                 busy_q;
	logic                 done_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]     dvd_q;
	logic [SLOT_W-1:0]    rem_q;
	logic [SIZE_W-1:0]    div_q;
	logic [SLOT_W:0]      trial;
	logic [SLOT_W:0]      div_ext;
	logic [SLOT_W-1:0]    rem_next;

	assign trial   = {rem_q, dvd_q[KEY_W-1]};
	assign div_ext = (SLOT_W + 1)'(div_q);

	always_comb begin
		if (trial >= div_ext) begin
			rem_next = SLOT_W'(trial - div_ext);
		end else begin
			rem_next = SLOT_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_CNT_W'(KEY_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ bench/linear_probe_hash_table_tb.sv @@
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
	import lph_pkg::*;

	// The fourth command code has no meaning in the block. It must answer
	// with not found and leave the table alone.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

	// The slowest items are probes over all 1024 slots.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 1100;

	// The long receiver hold-off starts once this many input beats have been
	// taken, which lands it in one of the small-table phases.
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 1500;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [KEY_W-1:0] key;
	} op_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_OUT_W-1:0] slot;
	} outcome_t;

	// Every input of the block has a known value from time zero on.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [CMD_W-1:0]      command = '0;
	logic [KEY_W-1:0]      key = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0;

	linear_probe_hash_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.slot      (slot),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the table. The key array is only read where the
	// occupied bit is set, just as in the block.
	logic [KEY_W-1:0] shadow_key [CAPACITY];
	bit               shadow_used [CAPACITY];
	int unsigned      shadow_size = CAPACITY;

	op_t      op_backlog [$];
	outcome_t awaited_results [$];
	op_t      next_op;
	outcome_t head_result;

	int ops_accepted = 0;
	int results_checked = 0;
	int mismatches = 0;
	int sizes_tried = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int cycle_count = 0;

	int burst_left = 0;
	int gap_left = 0;
	int ready_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit ready_now;

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one operation to the shadow table and returns the answer the
	// block must give. Insert stops at the first slot that holds the key or
	// is empty; remove and search always walk every slot in use and take the
	// first match, empty slots included.
	function automatic outcome_t probe_table(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
		outcome_t    res;
		int unsigned pos;
		bit          found;
		res.status = ST_NOT_FOUND;
		res.slot = '0;
		found = 1'b0;
		pos = k % shadow_size;
		if (cmd == CMD_INSERT) begin
			res.status = ST_FULL;
			for (int i = 0; i < shadow_size; i++) begin
				if (shadow_used[pos]) begin
					if (shadow_key[pos] == k) begin
						res.status = ST_DUPLICATE;
						res.slot = SLOT_OUT_W'(pos);
						break;
					end
				end else begin
					shadow_key[pos] = k;
					shadow_used[pos] = 1'b1;
					res.status = ST_OK;
					res.slot = SLOT_OUT_W'(pos);
					break;
				end
				pos = (pos + 1 == shadow_size) ? 0 : pos + 1;
			end
		end else if (cmd == CMD_REMOVE || cmd == CMD_SEARCH) begin
			for (int i = 0; i < shadow_size; i++) begin
				if (!found && shadow_used[pos] && shadow_key[pos] == k) begin
					found = 1'b1;
					res.status = ST_OK;
					res.slot = SLOT_OUT_W'(pos);
					if (cmd == CMD_REMOVE)
						shadow_used[pos] = 1'b0;
				end
				pos = (pos + 1 == shadow_size) ? 0 : pos + 1;
			end
		end
		return res;
	endfunction

	// Input driver. A beat is taken at an edge where valid and ready were
	// both high; the answer is worked out right then, so the queue of
	// awaited results stays in acceptance order. The sender offers beats in
	// bursts of random length with random gaps after each burst, and a gap
	// of zero gives stretches with no idling at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				awaited_results.push_back(probe_table(command, key));
				ops_accepted <= ops_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					next_op = op_backlog.pop_front();
					in_valid <= 1'b1;
					command <= next_op.command;
					key <= next_op.key;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The long hold-off runs in a process of its own. While it lasts the
	// receiver takes nothing, the output register fills, the next result
	// finishes behind it, and the block has to drop in_ready even though
	// the sender keeps offering beats.
	always @(posedge clk) begin
		if (!hold_done && ops_accepted == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Output monitor. Each result beat is checked field by field against the
	// oldest awaited answer. The receiver switches at random between always
	// ready, a coin toss each cycle, rarely ready and strict alternation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with nothing awaited, expected none, got status %0d slot %0d",
						$time, status, slot);
					mismatches++;
				end else begin
					head_result = awaited_results.pop_front();
					results_checked++;
					if (status !== head_result.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, head_result.status, status);
						mismatches++;
					end
					if (slot !== head_result.slot) begin
						$display("%0t: slot mismatch, expected %0d, got %0d",
							$time, head_result.slot, slot);
						mismatches++;
					end
					if (!$isunknown(status))
						status_seen[status]++;
				end
			end
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: begin
					ready_now = 1'b1;
				end
				1: begin
					ready_now = 1'($urandom_range(0, 1));
				end
				2: begin
					ready_now = ($urandom_range(0, 5) == 0);
				end
				default: begin
					ready_now = ~out_ready;
				end
			endcase
			out_ready <= ready_now && (hold_left == 0);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results still awaited",
				cycle_count, awaited_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic enqueue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k);
		op_t op;
		op.command = cmd;
		op.key = k;
		op_backlog.push_back(op);
	endtask

	// Waits on falling edges until every queued beat has been taken and
	// every awaited result has come back. Each beat yields exactly one
	// result, so the block is idle at that point.
	task automatic settle();
		while (op_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
	endtask

	// Writes table_size through its own channel. The shadow size follows the
	// block's clamping: zero means one slot, anything above the capacity
	// means the full table.
	task automatic write_size(input logic [CFG_W-1:0] size_word);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= size_word;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (size_word == 0)
			shadow_size = 1;
		else if (size_word > CAPACITY)
			shadow_size = CAPACITY;
		else
			shadow_size = 32'(size_word);
		sizes_tried++;
		@(negedge clk);
	endtask

	// One random phase. Most beats work on a small pool of keys, so inserts,
	// duplicates, removals and hits follow one another; half of the pool
	// shares the last home slot to force wrap-around probing, and on small
	// tables the pool outgrows the table so it fills up. The rest are fresh
	// random keys that mostly miss.
	task automatic run_phase(input logic [CFG_W-1:0] size_word, input int count);
		logic [KEY_W-1:0] pool [$];
		int unsigned      m;
		int unsigned      home;
		int unsigned      pick;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] k;
		settle();
		write_size(size_word);
		m = shadow_size;
		for (int i = 0; i < ((m + 3 < 32) ? m + 3 : 32); i++) begin
			home = (i % 2 == 0) ? m - 1 : $urandom_range(0, m - 1);
			pool.push_back(KEY_W'($urandom_range(0, KEY_MAX / m - 1) * m + home));
		end
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				cmd = CMD_INSERT;
			else if (pick < 70)
				cmd = CMD_REMOVE;
			else if (pick < 95)
				cmd = CMD_SEARCH;
			else
				cmd = CMD_UNUSED;
			if ($urandom_range(0, 99) < 88)
				k = pool[$urandom_range(0, pool.size() - 1)];
			else
				k = KEY_W'($urandom);
			enqueue(cmd, k);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed checks on the full table left by reset. The largest key
		// lands in the last slot, so a second key with the same home wraps
		// around to the front. Removing a key leaves a hole that a later
		// search must walk past, and an insert may then fill the hole with a
		// second copy of a key that already sits further along.
		enqueue(CMD_INSERT, '0);
		enqueue(CMD_INSERT, KEY_MAX);
		enqueue(CMD_INSERT, 31'd1023);
		enqueue(CMD_INSERT, '0);
		enqueue(CMD_SEARCH, KEY_MAX);
		enqueue(CMD_SEARCH, 31'd1023);
		enqueue(CMD_SEARCH, 31'd5);
		enqueue(CMD_REMOVE, '0);
		enqueue(CMD_SEARCH, 31'd1023);
		enqueue(CMD_REMOVE, 31'd5);
		enqueue(CMD_UNUSED, KEY_MAX);
		enqueue(CMD_INSERT, 31'd1023);
		enqueue(CMD_SEARCH, 31'd1023);

		// A size of zero clamps to a single slot, which already holds a key,
		// so the next insert finds the table full.
		settle();
		write_size('0);
		enqueue(CMD_INSERT, 31'd7);
		enqueue(CMD_SEARCH, 31'd1023);
		enqueue(CMD_REMOVE, 31'd1023);
		enqueue(CMD_INSERT, 31'd7);
		enqueue(CMD_INSERT, 31'd8);
		enqueue(CMD_SEARCH, 31'h5555_5555);
		enqueue(CMD_UNUSED, '0);

		// The largest register value clamps back to the full table; keys
		// stored under the small size stay where they were.
		settle();
		write_size({CFG_W{1'b1}});
		enqueue(CMD_SEARCH, 31'd7);
		enqueue(CMD_SEARCH, KEY_MAX);
		enqueue(CMD_INSERT, 31'h2AAA_AAAA);
		enqueue(CMD_REMOVE, KEY_MAX);

		// Random phases, mostly on small tables so each beat stays short.
		// The exact capacity and the single slot are also written directly.
		run_phase(11'd3, 52);
		run_phase(11'd1, 52);
		run_phase(11'd8, 52);
		run_phase(11'd2, 52);
		run_phase(CAPACITY, 20);
		run_phase(11'd16, 52);
		run_phase(11'd5, 52);
		run_phase(11'd31, 52);
		run_phase(11'd64, 52);
		run_phase(11'd13, 52);
		run_phase(11'd100, 52);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d operations over %0d table size settings, %0d results checked.",
			ops_accepted, sizes_tried + 1, results_checked);
		$display("Answers seen: %0d done, %0d not found, %0d duplicate, %0d full.",
			status_seen[ST_OK], status_seen[ST_NOT_FOUND],
			status_seen[ST_DUPLICATE], status_seen[ST_FULL]);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/lph_pkg.sv
hdl/lph_ram.sv
hdl/lph_mod.sv
hdl/linear_probe_hash_table.sv
bench/linear_probe_hash_table_tb.sv
